[rtl/core/nlis_pkg.sv]
// Shared types and defaults for the N-largest index selector.
package nlis_pkg;

   // Default configuration
   localparam int PICK_COUNT_DEF     = 5;
   localparam int ROW_LENGTH_MAX_DEF = 512;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int POS_W   = 9;

   // Input word: one row element
   typedef struct packed {
      logic [VALUE_W-1:0] cost_value;
      logic               row_end;
   } req_type;

   // Result word: one selected element
   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] chosen_value;
      logic               final_pick;
   } rsp_type;

   // One held list entry
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } entry_type;

   // Handoff from the insertion list to the drain bank
   typedef struct packed {
      logic load;
   } handoff_type;

endpackage

[rtl/core/top_n_largest_index_select.sv]
// Top level of the N-largest index selector: input register, list and drain.
//
// Feed a row of unsigned Q16.16 values one word per cycle on req_word with
// start; a word is taken on a clock edge where start is high and busy is low.
// Mark the last element with row_end. Rows stream at one element per cycle
// while busy is low, via the input register into the insertion list. A row
// end loads the drain bank; one result per cycle then leaves through a result
// register, up to PICK_COUNT of them, largest value first, equal values in
// row order, with final_pick on the last. Results are shown for exactly one
// cycle and cannot be stalled. busy is high for the cycle after a row end is
// taken and while more than two results of a finished row remain to go out;
// the next row may be loaded while the previous one drains. Elements past
// ROW_LENGTH_MAX are ignored, though their row_end still closes the row.
module top_n_largest_index_select #(
   parameter int PICK_COUNT     = nlis_pkg::PICK_COUNT_DEF,
   parameter int ROW_LENGTH_MAX = nlis_pkg::ROW_LENGTH_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nlis_pkg::req_type req_word,
   output logic              rsp_strobe,
   output nlis_pkg::rsp_type rsp_word
);

   localparam int CNT_W = $clog2(PICK_COUNT + 3);

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   nlis_pkg::req_type     stage_word_ff;
   nlis_pkg::handoff_type handoff;
   logic [CNT_W-1:0]      load_count;
   nlis_pkg::entry_type   load_entries [PICK_COUNT];
   logic                  drain_full;

   // Hold off while a row end waits to load or the drain bank is too full
   assign busy           = (stage_valid_ff && stage_word_ff.row_end) || drain_full;
   assign stage_valid_in = start && !busy;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_word_ff <= req_word;
   end

   nlis_insert #(
      .PICK_COUNT     (PICK_COUNT),
      .ROW_LENGTH_MAX (ROW_LENGTH_MAX)
   ) u_insert (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid_ff),
      .in_word      (stage_word_ff),
      .handoff      (handoff),
      .load_count   (load_count),
      .load_entries (load_entries)
   );

   nlis_drain #(
      .PICK_COUNT (PICK_COUNT)
   ) u_drain (
      .clock        (clock),
      .reset        (reset),
      .handoff      (handoff),
      .load_count   (load_count),
      .load_entries (load_entries),
      .drain_full   (drain_full),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word)
   );

endmodule

[rtl/core/nlis_insert.sv]
// Sorted top-N list with parallel insertion.
module nlis_insert #(
   parameter int PICK_COUNT     = nlis_pkg::PICK_COUNT_DEF,
   parameter int ROW_LENGTH_MAX = nlis_pkg::ROW_LENGTH_MAX_DEF,
   localparam int CNT_W         = $clog2(PICK_COUNT + 3)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nlis_pkg::req_type   in_word,
   output nlis_pkg::handoff_type handoff,
   output logic [CNT_W-1:0]    load_count,
   output nlis_pkg::entry_type load_entries [PICK_COUNT]
);

   localparam int IPOS_W = $clog2(ROW_LENGTH_MAX + 1);
   localparam logic [IPOS_W-1:0] POS_LIMIT = IPOS_W'(ROW_LENGTH_MAX);

   nlis_pkg::entry_type    entry_ff [PICK_COUNT];
   nlis_pkg::entry_type    entry_in [PICK_COUNT];
   logic [PICK_COUNT-1:0]  valid_ff;
   logic [PICK_COUNT-1:0]  valid_in;
   logic [PICK_COUNT-1:0]  valid_nx;
   logic [IPOS_W-1:0]      ipos_ff;
   logic [IPOS_W-1:0]      ipos_in;
   logic [PICK_COUNT-1:0]  ins;
   logic                   take;
   logic                   row_done;
   nlis_pkg::entry_type    new_entry;

   // Compare the incoming value against every held entry and build the next list
   always_comb begin
      take                = in_valid && (ipos_ff < POS_LIMIT);
      row_done            = in_valid && in_word.row_end;
      new_entry.value     = in_word.cost_value;
      new_entry.position  = nlis_pkg::POS_W'(ipos_ff);

      // Insertion point: first slot that is empty or strictly smaller
      for (int i = 0; i < PICK_COUNT; i++) begin
         ins[i] = !valid_ff[i] || (entry_ff[i].value < in_word.cost_value);
      end

      // Slot zero takes the new value or keeps its own
      if (take && ins[0]) begin
         entry_in[0] = new_entry;
      end else begin
         entry_in[0] = entry_ff[0];
      end
      valid_nx[0] = valid_ff[0] || take;

      // Remaining slots: new value at the boundary, shifted entry below it
      for (int i = 1; i < PICK_COUNT; i++) begin
         if (take && ins[i] && !ins[i-1]) begin
            entry_in[i] = new_entry;
         end else if (take && ins[i]) begin
            entry_in[i] = entry_ff[i-1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         valid_nx[i] = valid_ff[i] || (take && valid_ff[i-1]);
      end

      // Advance the position counter, saturating at the row limit
      ipos_in = take ? ipos_ff + IPOS_W'(1) : ipos_ff;

      // Clear the list at row end
      if (row_done) begin
         valid_in = '0;
         ipos_in  = '0;
      end else begin
         valid_in = valid_nx;
      end

      handoff.load      = row_done;
      load_count        = CNT_W'($countones(valid_nx));
      load_entries      = entry_in;
   end

   // Hold the list entries
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Hold the list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ipos_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         ipos_ff  <= ipos_in;
      end
   end

endmodule

[rtl/core/nlis_drain.sv]
// Drain bank that shifts a finished list out one result word per cycle.
module nlis_drain #(
   parameter int PICK_COUNT = nlis_pkg::PICK_COUNT_DEF,
   localparam int CNT_W     = $clog2(PICK_COUNT + 3)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nlis_pkg::handoff_type handoff,
   input  logic [CNT_W-1:0]     load_count,
   input  nlis_pkg::entry_type  load_entries [PICK_COUNT],
   output logic                 drain_full,
   output logic                 rsp_strobe,
   output nlis_pkg::rsp_type    rsp_word
);

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   nlis_pkg::entry_type drain_ff [PICK_COUNT];
   nlis_pkg::entry_type drain_in [PICK_COUNT];
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                strobe_ff;
   logic                strobe_in;
   nlis_pkg::rsp_type   rsp_ff;
   nlis_pkg::rsp_type   rsp_in;
   logic                emit;

   // Emit the head entry, then shift or reload the bank
   always_comb begin
      emit                = (cnt_ff != '0);
      strobe_in           = emit;
      rsp_in.position     = drain_ff[0].position;
      rsp_in.chosen_value = drain_ff[0].value;
      rsp_in.final_pick   = (cnt_ff == CNT_ONE);

      if (handoff.load) begin
         drain_in = load_entries;
         cnt_in   = load_count;
      end else if (emit) begin
         for (int i = 0; i < PICK_COUNT - 1; i++) begin
            drain_in[i] = drain_ff[i+1];
         end
         drain_in[PICK_COUNT-1] = drain_ff[PICK_COUNT-1];
         cnt_in = cnt_ff - CNT_ONE;
      end else begin
         drain_in = drain_ff;
         cnt_in   = cnt_ff;
      end
   end

   // Hold the bank and the result payload
   always_ff @(posedge clock) begin
      drain_ff <= drain_in;
      rsp_ff   <= rsp_in;
   end

   // Hold the count and the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   assign drain_full = (cnt_ff > CNT_TWO);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
